FILE: hw/rtl/odo_pkg.sv
// Package for the differential-drive odometry block: shared widths, the
// CORDIC arctangent table, the control structs and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package odo_pkg;

    // datapath widths
    localparam int CW       = 54;   // CORDIC x/y lanes
    localparam int ZW       = 33;   // CORDIC angle lane, full turn = 2^32
    localparam int SUMW     = 26;   // wheel distances and their sum/difference
    localparam int DW       = 9;    // wrapped encoder difference
    localparam int GAIN_Q30 = 652032874;

    // register map (word index)
    localparam logic REG_WHEEL_BASE    = 1'b0;
    localparam logic REG_TICK_DISTANCE = 1'b1;

    // atan(2^-i) with full turn = 2^32
    function automatic logic [29:0] atan_tab(input logic [4:0] idx);
        logic [29:0] val;
        unique case (idx)
            5'd0:    val = 30'h20000000;
            5'd1:    val = 30'h12E4051E;
            5'd2:    val = 30'h09FB385B;
            5'd3:    val = 30'h051111D4;
            5'd4:    val = 30'h028B0D43;
            5'd5:    val = 30'h0145D7E1;
            5'd6:    val = 30'h00A2F61E;
            5'd7:    val = 30'h00517C55;
            5'd8:    val = 30'h0028BE53;
            5'd9:    val = 30'h00145F2F;
            5'd10:   val = 30'h000A2F98;
            5'd11:   val = 30'h000517CC;
            5'd12:   val = 30'h00028BE6;
            5'd13:   val = 30'h000145F3;
            5'd14:   val = 30'h0000A2FA;
            5'd15:   val = 30'h0000517D;
            5'd16:   val = 30'h000028BE;
            5'd17:   val = 30'h0000145F;
            5'd18:   val = 30'h00000A30;
            5'd19:   val = 30'h00000518;
            5'd20:   val = 30'h0000028C;
            5'd21:   val = 30'h00000146;
            5'd22:   val = 30'h000000A3;
            5'd23:   val = 30'h00000051;
            default: val = 30'h0;
        endcase
        return val;
    endfunction

    typedef struct packed {
        logic                 start;
        logic                 vectoring;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_cmd_t;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_ROT_GO,
        ST_ROT,
        ST_VEC_GO,
        ST_WAIT,
        ST_UPD
    } state_t;

endpackage

FILE: hw/rtl/odo_cordic.sv
// Shared iterative CORDIC unit: one micro-rotation per cycle, rotation or
// vectoring mode. Depends on odo_pkg.
`timescale 1ns / 1ps

module odo_cordic #(
    parameter int STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  odo_pkg::cordic_cmd_t cmd,
    output odo_pkg::cordic_res_t res
);
    import odo_pkg::*;

    localparam int IW = $clog2(STEPS);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 mode_reg;
    logic [IW-1:0]        iter_reg;
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;

    logic                 ccw;
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] ang;

    // one micro-rotation
    always_comb
    begin
        ccw = mode_reg ? y_reg[CW-1] : ~z_reg[ZW-1];
        xs  = x_reg >>> iter_reg;
        ys  = y_reg >>> iter_reg;
        ang = ZW'(atan_tab(5'(iter_reg)));
        if (ccw)
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - ang;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + ang;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == IW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // vector and angle lanes
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg <= cmd.vectoring;
            x_reg    <= cmd.x;
            y_reg    <= cmd.y;
            z_reg    <= cmd.z;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign res.done = done_reg;
    assign res.x    = x_reg;
    assign res.y    = y_reg;
    assign res.z    = z_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("cordic restarted while busy");

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("cordic done without a run");

endmodule

FILE: hw/rtl/odo_mul.sv
// Shift-and-add multiplier: sin and cos times the summed wheel distance,
// one multiplier bit per cycle. Depends on odo_pkg.
`timescale 1ns / 1ps

module odo_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [FRAC_BITS+2:0]        a0,
    input  logic signed [FRAC_BITS+2:0]        a1,
    input  logic signed [odo_pkg::SUMW-1:0]    b,
    output logic                               done,
    output logic signed [FRAC_BITS+odo_pkg::SUMW+3:0] p0,
    output logic signed [FRAC_BITS+odo_pkg::SUMW+3:0] p1
);
    import odo_pkg::*;

    localparam int PW = FRAC_BITS + SUMW + 4;
    localparam int KW = $clog2(SUMW);

    logic                 busy_reg;
    logic                 done_reg;
    logic [KW-1:0]        k_reg;
    logic [SUMW-1:0]      b_reg;
    logic signed [PW-1:0] m0_reg, m1_reg;
    logic signed [PW-1:0] acc0_reg, acc1_reg;
    logic signed [PW-1:0] add0, add1;

    // partial product of this bit; the top bit carries negative weight
    always_comb
    begin
        add0 = '0;
        add1 = '0;
        if (b_reg[0])
        begin
            add0 = (k_reg == KW'(SUMW - 1)) ? -m0_reg : m0_reg;
            add1 = (k_reg == KW'(SUMW - 1)) ? -m1_reg : m1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg + 1'b1;
                if (k_reg == KW'(SUMW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            b_reg    <= b;
            m0_reg   <= PW'(a0);
            m1_reg   <= PW'(a1);
            acc0_reg <= '0;
            acc1_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg    <= b_reg >> 1;
            m0_reg   <= m0_reg <<< 1;
            m1_reg   <= m1_reg <<< 1;
            acc0_reg <= acc0_reg + add0;
            acc1_reg <= acc1_reg + add1;
        end
    end

    assign done = done_reg;
    assign p0   = acc0_reg;
    assign p1   = acc1_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier restarted while busy");

endmodule

FILE: hw/rtl/differential_drive_odometry_top.sv
// Top level of the differential-drive odometry block: APB registers, pose
// state and the step sequencer. Depends on odo_pkg, odo_cordic, odo_mul.
`timescale 1ns / 1ps

// Usage:
//   Input stream s_*: one transfer per item. s_tuser is the action (0 wheel
//   step, 1 load pose). s_tdata carries counts and the pose to load.
//   Output stream m_*: one transfer per item with the pose after the step.
//   APB port: register 0 wheel_base at 0x0, register 1 tick_distance at 0x4.
//   Write registers only while no item is in flight.
// Sequence:
//   A load item goes from ST_IDLE to ST_UPD, which raises m_tvalid once the
//   output is free. A wheel step runs a sin/cos run of the shared CORDIC
//   unit, then an arctangent run of the same unit (skipped when both wheels
//   move alike) beside the shift-add multiplier, which sets the tail at the
//   default. One item is in work at a time; s_tready is high only when the
//   sequencer is idle, so a new item is taken only once the last is through it.
// Reset: pose, last counts and heading clear to zero, registers take their
//   defaults, no result is pending.
// Stall: a finished pose holds on m_tdata while m_tready is low; the next
//   item may be accepted meanwhile but its result waits for the transfer.
module differential_drive_odometry_top #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // left_count, right_count, load_x, load_y, load_heading
    input  logic        s_tuser,   // action
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // pose_x, pose_y, pose_heading
);
    import odo_pkg::*;

    localparam int SW = FRAC_BITS + 3;
    localparam int PW = FRAC_BITS + SUMW + 4;
    localparam logic signed [CW-1:0] ROT_X0 = CW'(GAIN_Q30 >> (30 - FRAC_BITS));

    state_t state_reg, state_next;

    logic [19:0] wheel_base_reg;
    logic [15:0] tick_distance_reg;

    logic [31:0] pos_x_reg, pos_y_reg;
    logic [15:0] heading_reg;
    logic [7:0]  last_left_reg, last_right_reg;
    logic        m_tvalid_reg;

    // latched item
    logic        action_reg;
    logic [7:0]  lc_reg, rc_reg;
    logic [31:0] load_x_reg, load_y_reg;
    logic [15:0] load_heading_reg;

    logic signed [SUMW-1:0] dl_reg, dr_reg;
    logic signed [SW-1:0]   sin_reg, cos_reg;
    logic [15:0]            dth_reg;
    logic                   mul_done_reg, vec_done_reg;

    cordic_cmd_t cmd;
    cordic_res_t res;
    logic        mul_start, mul_done;
    logic signed [PW-1:0] p0, p1;

    logic                   accept, apb_wr, upd_go;
    logic [7:0]             dl8, dr8;
    logic signed [DW-1:0]   diff_l, diff_r;
    logic signed [SUMW-1:0] dl_w, dr_w, dsum, ddiff;
    logic signed [ZW-1:0]   z_head;
    logic signed [ZW-1:0]   z_round, dth_w;
    logic signed [PW-1:0]   rx, ry, dx_w, dy_w;

    assign accept = s_tvalid && s_tready;
    assign apb_wr = psel && penable && pwrite && pready;
    assign upd_go = (state_reg == ST_UPD) && (!m_tvalid_reg || m_tready);

    // APB registers
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TICK_DISTANCE) ? {16'b0, tick_distance_reg}
                                                    : {12'b0, wheel_base_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_base_reg    <= 20'd85197;
            tick_distance_reg <= 16'd1638;
        end
        else if (apb_wr)
        begin
            if (paddr[2] == REG_WHEEL_BASE)
                wheel_base_reg <= pwdata[19:0];
            else
                tick_distance_reg <= pwdata[15:0];
        end
    end

    // wrapped encoder differences scaled to distance
    always_comb
    begin
        dl8    = lc_reg - last_left_reg;
        dr8    = rc_reg - last_right_reg;
        diff_l = (dl8 > 8'd128) ? {1'b1, dl8} : {1'b0, dl8};
        diff_r = (dr8 > 8'd128) ? {1'b1, dr8} : {1'b0, dr8};
        dl_w   = SUMW'(diff_l) * SUMW'($signed({1'b0, tick_distance_reg}));
        dr_w   = SUMW'(diff_r) * SUMW'($signed({1'b0, tick_distance_reg}));
        dsum   = dl_reg + dr_reg;
        ddiff  = dr_reg - dl_reg;
        z_head = {heading_reg[15], heading_reg, 16'b0};
    end

    // rounding of products and turn angle
    always_comb
    begin
        rx      = p0 + (PW'(1) <<< FRAC_BITS);
        ry      = p1 + (PW'(1) <<< FRAC_BITS);
        dx_w    = rx >>> (FRAC_BITS + 1);
        dy_w    = ry >>> (FRAC_BITS + 1);
        z_round = res.z + ZW'(32768);
        dth_w   = z_round >>> 16;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        mul_start     = 1'b0;
        cmd.start     = 1'b0;
        cmd.vectoring = 1'b0;
        cmd.x         = ROT_X0;
        cmd.y         = '0;
        cmd.z         = z_head;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = s_tuser ? ST_UPD : ST_DIST;
            end
            ST_DIST:
                state_next = ST_ROT_GO;
            ST_ROT_GO:
            begin
                // fold headings beyond a quarter turn
                cmd.start = 1'b1;
                if (z_head > 33'sh040000000)
                begin
                    cmd.z = z_head - 33'sh080000000;
                    cmd.x = -ROT_X0;
                end
                else if (z_head < -33'sh040000000)
                begin
                    cmd.z = z_head + 33'sh080000000;
                    cmd.x = -ROT_X0;
                end
                state_next = ST_ROT;
            end
            ST_ROT:
                if (res.done)
                    state_next = ST_VEC_GO;
            ST_VEC_GO:
            begin
                mul_start     = 1'b1;
                cmd.start     = (ddiff != '0);
                cmd.vectoring = 1'b1;
                cmd.x         = CW'({wheel_base_reg, 24'b0});
                cmd.y         = CW'(ddiff) <<< 24;
                cmd.z         = '0;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
                if (mul_done_reg && vec_done_reg)
                    state_next = ST_UPD;
            ST_UPD:
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // item latch and intermediate results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg       <= s_tuser;
            lc_reg           <= s_tdata[7:0];
            rc_reg           <= s_tdata[15:8];
            load_x_reg       <= s_tdata[47:16];
            load_y_reg       <= s_tdata[79:48];
            load_heading_reg <= s_tdata[95:80];
        end
        if (state_reg == ST_DIST)
        begin
            dl_reg <= dl_w;
            dr_reg <= dr_w;
        end
        if (state_reg == ST_ROT && res.done)
        begin
            sin_reg <= res.y[SW-1:0];
            cos_reg <= res.x[SW-1:0];
        end
        if (state_reg == ST_VEC_GO)
            dth_reg <= '0;
        else if (state_reg == ST_WAIT && res.done)
            dth_reg <= dth_w[15:0];
    end

    // completion flags of the parallel tail
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_done_reg <= 1'b0;
            vec_done_reg <= 1'b0;
        end
        else if (state_reg == ST_VEC_GO)
        begin
            mul_done_reg <= 1'b0;
            vec_done_reg <= (ddiff == '0);
        end
        else if (state_reg == ST_WAIT)
        begin
            if (mul_done)
                mul_done_reg <= 1'b1;
            if (res.done)
                vec_done_reg <= 1'b1;
        end
    end

    // pose state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            heading_reg    <= '0;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            if (upd_go)
            begin
                m_tvalid_reg <= 1'b1;
                if (action_reg)
                begin
                    pos_x_reg   <= load_x_reg;
                    pos_y_reg   <= load_y_reg;
                    heading_reg <= load_heading_reg;
                end
                else
                begin
                    pos_x_reg      <= pos_x_reg + dx_w[31:0];
                    pos_y_reg      <= pos_y_reg + dy_w[31:0];
                    heading_reg    <= heading_reg - dth_reg;
                    last_left_reg  <= lc_reg;
                    last_right_reg <= rc_reg;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {heading_reg, pos_y_reg, pos_x_reg};

    odo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    odo_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a0    (sin_reg),
        .a1    (cos_reg),
        .b     (dsum),
        .done  (mul_done),
        .p0    (p0),
        .p1    (p1)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input accepted again before the step finished");

    a_pose_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_UPD) |=> $stable(pos_x_reg) && $stable(heading_reg))
        else $error("pose changed outside the update state");

    a_result_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        upd_go |=> m_tvalid)
        else $error("update finished without presenting a result");

endmodule

FILE: dv/odo_checker.sv
// Checker for the differential-drive odometry block: watches the APB port and
// both streams, predicts each pose and compares it. Depends on odo_pkg.
`timescale 1ns / 1ps

module odo_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,   // left_count, right_count, load_x, load_y, load_heading
    input  logic        s_tuser,   // action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,   // pose_x, pose_y, pose_heading
    output int          fail_count,
    output int          pending
);
    import odo_pkg::*;

    localparam int STEPS = 16;
    localparam int FRAC  = 16;

    typedef struct packed {
        logic [15:0] hd;
        logic [31:0] py;
        logic [31:0] px;
    } pose_t;

    logic [19:0] wb_q;
    logic [15:0] td_q;
    logic [31:0] px_q, py_q;
    logic [15:0] hd_q;
    logic [7:0]  ll_q, lr_q;
    pose_t       pose_fifo[$];

    function automatic longint asr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint tab(int i);
        return longint'(atan_tab(5'(i)));
    endfunction

    function automatic longint enc_delta(logic [7:0] now, logic [7:0] old);
        longint d;
        d = longint'(8'(now - old));
        return (d > 128) ? d - 256 : d;
    endfunction

    // rotation mode: sin and cos of the heading
    task automatic rotate(input logic [15:0] h, output longint s, output longint c);
        longint z, x, y, xs, ys;
        z = (h >= 16'd32768 ? longint'(h) - 65536 : longint'(h)) * 65536;
        x = longint'(GAIN_Q30) >>> (30 - FRAC);
        y = 0;
        if (z > 64'sh40000000) begin
            z -= 64'sh80000000;
            x = -x;
        end else if (z < -64'sh40000000) begin
            z += 64'sh80000000;
            x = -x;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= tab(i);
            end else begin
                x += ys; y -= xs; z += tab(i);
            end
        end
        c = x;
        s = y;
    endtask

    // vectoring mode: heading change from wheel difference and base
    function automatic longint turn_of(longint num, longint den);
        longint x, y, z, xs, ys;
        if (num == 0) return 0;
        x = den * 16777216;
        y = num * 16777216;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += tab(i);
            end else begin
                x -= ys; y += xs; z -= tab(i);
            end
        end
        return asr(z + 32768, 16);
    endfunction

    task automatic advance(input logic act, input logic [95:0] d);
        longint dl, dr, s, c, dx, dy, dth;
        pose_t p;
        if (act) begin
            px_q = d[47:16];
            py_q = d[79:48];
            hd_q = d[95:80];
        end else begin
            dl = enc_delta(d[7:0], ll_q) * longint'(td_q);
            dr = enc_delta(d[15:8], lr_q) * longint'(td_q);
            rotate(hd_q, s, c);
            dx = asr(s * (dl + dr) + (64'sd1 <<< FRAC), FRAC + 1);
            dy = asr(c * (dl + dr) + (64'sd1 <<< FRAC), FRAC + 1);
            dth = turn_of(dr - dl, longint'(wb_q));
            px_q = px_q + dx[31:0];
            py_q = py_q + dy[31:0];
            hd_q = hd_q - dth[15:0];
            ll_q = d[7:0];
            lr_q = d[15:8];
        end
        p.px = px_q;
        p.py = py_q;
        p.hd = hd_q;
        pose_fifo.push_back(p);
    endtask

    always @(posedge clk or negedge rst_n) begin
        pose_t want, got;
        if (!rst_n) begin
            wb_q = 20'd85197;
            td_q = 16'd1638;
            px_q = '0; py_q = '0; hd_q = '0; ll_q = '0; lr_q = '0;
            pose_fifo.delete();
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_TICK_DISTANCE) td_q = pwdata[15:0];
                else wb_q = pwdata[19:0];
            end
            // result first: its expectation was queued on an earlier transfer
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pose_fifo.size() == 0) begin
                    $display("%0t: unexpected pose %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = pose_fifo.pop_front();
                    if (got.px !== want.px)
                        $display("%0t: pose_x expected %h actual %h", $time, want.px, got.px);
                    if (got.py !== want.py)
                        $display("%0t: pose_y expected %h actual %h", $time, want.py, got.py);
                    if (got.hd !== want.hd)
                        $display("%0t: heading expected %h actual %h", $time, want.hd, got.hd);
                    if (got !== want) fail_count++;
                end
            end
            if (s_tvalid && s_tready) advance(s_tuser, s_tdata);
        end
        pending = pose_fifo.size();
    end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the differential-drive odometry block: clock, reset, APB
// writes, stream stimulus and verdict. Depends on odo_pkg and odo_checker.
`timescale 1ns / 1ps

module tb_top;
    import odo_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    int          fail_count, pending;
    int          cycles = 0;
    logic [7:0]  lcnt = '0, rcnt = '0;

    always #2 clk = ~clk;

    differential_drive_odometry_top u_dut (.*);

    odo_checker u_chk (.*);

    // timeout watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stall per transfer
    initial begin
        int gap;
        forever begin
            @(posedge clk);
            if (m_tready && m_tvalid) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                if (gap != 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    m_tready <= 1'b1;
                end
            end else if (!m_tready) begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic reg_idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // tvalid stays high across back-to-back items; it drops before a gap
    task automatic send(input logic act, input logic [95:0] d, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1; s_tuser <= act; s_tdata <= d;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wheel(input logic [7:0] l, input logic [7:0] r, input bit burst);
        send(1'b0, {$urandom(), $urandom(), $urandom()} & ~96'hFFFF | {r, l}, burst);
    endtask

    task automatic load_pose(input logic [31:0] x, input logic [31:0] y,
                             input logic [15:0] h, input bit burst);
        logic [15:0] junk;
        junk = $urandom();
        send(1'b1, {h, y, x, junk}, burst);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        bit burst;
        for (int i = 0; i < n; i++) begin
            burst = ($urandom_range(0, 9) < 3);
            case ($urandom_range(0, 9))
                0:       load_pose($urandom(), $urandom(), $urandom(), burst);
                1:       wheel($urandom(), $urandom(), burst);
                default: begin
                    // realistic small motion with occasional large swings
                    lcnt = lcnt + 8'($urandom_range(0, 20) - 10);
                    rcnt = rcnt + 8'($urandom_range(0, 20) - 10);
                    if ($urandom_range(0, 15) == 0) lcnt = lcnt + 8'd128;
                    wheel(lcnt, rcnt, burst);
                end
            endcase
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: defaults
        wheel(8'd10, 8'd10, 1'b0);      // first step from zero, straight
        wheel(8'd138, 8'd139, 1'b0);    // +128 stays positive, +129 wraps to -127
        wheel(8'd9, 8'd10, 1'b0);       // -129 / -129 wraps
        wheel(8'd9, 8'd60, 1'b0);       // turn left
        wheel(8'd200, 8'd60, 1'b0);     // left wheel wraps back, turn left
        load_pose(32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 1'b0);
        wheel(8'd72, 8'd188, 1'b1);
        load_pose(32'h0, 32'h0, 16'h8000, 1'b0);
        wheel(8'd72, 8'd60, 1'b0);
        load_pose(32'hFFFFFFFF, 32'h1, 16'h4000, 1'b0);
        wheel(8'd255, 8'd0, 1'b0);
        load_pose(32'h12345678, 32'h87654321, 16'hC000, 1'b0);
        wheel(8'd0, 8'd255, 1'b0);
        wheel(8'd128, 8'd128, 1'b0);
        drain();

        // extremes of both registers
        reg_write(REG_WHEEL_BASE, 32'hFFFFFFFF);
        reg_write(REG_TICK_DISTANCE, 32'hFFFFFFFF);
        wheel(8'd0, 8'd128, 1'b0);
        wheel(8'd129, 8'd129, 1'b0);
        wheel(8'd1, 8'd2, 1'b0);
        drain();
        reg_write(REG_WHEEL_BASE, 32'd1);
        reg_write(REG_TICK_DISTANCE, 32'd1);
        wheel(8'd50, 8'd40, 1'b0);
        wheel(8'd60, 8'd90, 1'b0);
        drain();
        reg_write(REG_WHEEL_BASE, 32'd0);   // zero base
        reg_write(REG_TICK_DISTANCE, 32'h10000);  // masked to zero ticks
        wheel(8'd70, 8'd100, 1'b0);
        wheel(8'd10, 8'd100, 1'b0);
        drain();

        // random phases over several settings
        lcnt = 8'd10; rcnt = 8'd100;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin reg_write(REG_WHEEL_BASE, 32'd85197);
                          reg_write(REG_TICK_DISTANCE, 32'd1638); end
                1: begin reg_write(REG_WHEEL_BASE, 32'hFFFFF);
                          reg_write(REG_TICK_DISTANCE, 32'hFFFF); end
                2: begin reg_write(REG_WHEEL_BASE, 32'd1);
                          reg_write(REG_TICK_DISTANCE, 32'd1); end
                default: begin
                    reg_write(REG_WHEEL_BASE, $urandom());
                    reg_write(REG_TICK_DISTANCE, $urandom());
                end
            endcase
            random_phase(250);
            drain();
        end

        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
